>>> src/dpmg_pkg.sv
// Shared types and constants for the drum pattern map generator.
// No dependencies; imported by drum_pattern_map_generator and its testbench.
`default_nettype none

package dpmg_pkg;

    localparam int LANES      = 3;
    localparam int STEPS      = 32;
    localparam int MAP_NODES  = 5;
    localparam int NODE_COUNT = MAP_NODES * MAP_NODES;
    localparam int MEM_DEPTH  = LANES * NODE_COUNT * STEPS;
    localparam int STEP_W     = $clog2(STEPS);
    localparam int ROW_W      = $clog2(LANES * NODE_COUNT);
    localparam int ADDR_W     = ROW_W + STEP_W;

    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_INC  = 32'd1013904223;
    localparam logic [31:0] LCG_SEED = 32'hDEADBEEF;

    localparam logic [7:0] MAP_X_RESET  = 8'd128;
    localparam logic [7:0] MAP_Y_RESET  = 8'd128;
    localparam logic [7:0] ACCENT_RESET = 8'd192;
    localparam logic [7:0] BYTE_MAX     = 8'd255;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_LOAD    = 2'd1,
        OP_RESTART = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_MAP_X      = 3'd0,
        CFG_MAP_Y      = 3'd1,
        CFG_DENSITY0   = 3'd2,
        CFG_DENSITY1   = 3'd3,
        CFG_DENSITY2   = 3'd4,
        CFG_RANDOMNESS = 3'd5,
        CFG_ACCENT     = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MX0,
        ST_MX1,
        ST_MY,
        ST_TH,
        ST_JMUL,
        ST_JADD,
        ST_FIRE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> src/drum_pattern_map_generator.sv
// Drum pattern map generator top level: pattern memory, lane sequencer, output register.
// Depends on dpmg_pkg.
//
// A tick transaction runs the lane sequencer over the lanes in turn. Each of the three lanes
// takes four corner reads through the single port of the 2400 x 8 pattern memory and three
// interpolation steps. When randomness is nonzero it also takes two jitter steps through one
// shared 9x9 multiplier. The trigger decision follows, and after the last lane the done
// state loads the output register. That last state waits for as long as the previous result
// has not been taken. The sequencer then returns to idle, and the next transaction is accepted
// in the following cycle, so a new tick is taken only once the previous one has loaded the
// output register. Load and restart transactions are accepted in idle and give no result.
// Input is taken whenever the sequencer is idle, also while a result still waits in the output register.
`default_nettype none

module drum_pattern_map_generator
    import dpmg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [1:0]  load_lane,
    input  wire logic [4:0]  load_node,
    input  wire logic [4:0]  load_step,
    input  wire logic [7:0]  load_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       trigger_mask,
    output logic [2:0]       accent_mask,
    output logic [4:0]       evaluated_step,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [7:0] map_x_reg, map_y_reg, randomness_reg, accent_reg;
    logic [7:0] density_reg [LANES];

    logic [STEP_W-1:0] step_reg, eval_step_reg;
    logic [31:0]       lcg_reg;
    logic [1:0]        lane_reg, cnt_reg, rd_idx_reg;
    logic              rd_pend_reg;
    logic              out_valid_reg;
    logic [2:0]        out_trig_reg, out_acc_reg, trig_reg, acc_reg;

    logic [7:0]         mem [MEM_DEPTH];
    logic [7:0]         mem_q_reg;
    logic [7:0]         corner_reg [4];
    logic signed [17:0] prod_reg;
    logic [7:0]         r0_reg, th_reg;
    logic               acc_hit_reg;

    logic              in_fire, tick_fire, load_ok, mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr, load_addr, rd_addr;
    logic [2:0]        nx, ny;
    logic [4:0]        rd_node;
    logic [7:0]        xf, yf;

    logic signed [8:0]  mul_a, mul_b;
    logic signed [17:0] mul_res;
    logic [7:0]         lerp_base;
    logic signed [9:0]  lerp_sum;
    logic [7:0]         clamped;
    logic               fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign tick_fire = in_fire && (opcode_t'(opcode) == OP_TICK);

    assign out_valid      = out_valid_reg;
    assign trigger_mask   = out_trig_reg;
    assign accent_mask    = out_acc_reg;
    assign evaluated_step = eval_step_reg;

    // Memory addressing: row = lane * 25 + node, address = {row, step}
    assign load_ok   = (load_lane < 2'(LANES)) && (load_node < 5'(NODE_COUNT));
    assign load_addr = {7'(load_lane) * 7'(NODE_COUNT) + 7'(load_node), load_step};

    assign nx      = {1'b0, map_x_reg[7:6]} + {2'b00, cnt_reg[0]};
    assign ny      = {1'b0, map_y_reg[7:6]} + {2'b00, cnt_reg[1]};
    assign rd_node = 5'(ny) * 5'(MAP_NODES) + 5'(nx);
    assign rd_addr = {7'(lane_reg) * 7'(NODE_COUNT) + 7'(rd_node), step_reg};

    assign mem_we   = in_fire && (opcode_t'(opcode) == OP_LOAD) && load_ok;
    assign mem_re   = (state_reg == ST_READ);
    assign mem_addr = mem_we ? load_addr : rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= load_value;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    assign xf = {map_x_reg[5:0], 2'b00};
    assign yf = {map_y_reg[5:0], 2'b00};

    // Shared adder: base + floor(prod / 256)
    always_comb
    begin
        case (state_reg)
            ST_MX1:  lerp_base = corner_reg[0];
            ST_MY:   lerp_base = corner_reg[2];
            ST_TH:   lerp_base = r0_reg;
            default: lerp_base = th_reg;
        endcase
        lerp_sum = $signed({2'b00, lerp_base}) + 10'(prod_reg >>> 8);
    end

    // Shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_MX0:
            begin
                mul_a = $signed({1'b0, corner_reg[1]}) - $signed({1'b0, corner_reg[0]});
                mul_b = $signed({1'b0, xf});
            end
            ST_MX1:
            begin
                mul_a = $signed({1'b0, corner_reg[3]}) - $signed({1'b0, corner_reg[2]});
                mul_b = $signed({1'b0, xf});
            end
            ST_MY:
            begin
                mul_a = $signed({1'b0, lerp_sum[7:0]}) - $signed({1'b0, r0_reg});
                mul_b = $signed({1'b0, yf});
            end
            default:
            begin
                mul_a = $signed({~lcg_reg[23], ~lcg_reg[23], lcg_reg[22:16]});
                mul_b = $signed({1'b0, randomness_reg});
            end
        endcase
        mul_res = mul_a * mul_b;
    end

    always_comb
    begin
        if (lerp_sum < 10'sd0)
        begin
            clamped = 8'd0;
        end
        else if (lerp_sum > 10'sd255)
        begin
            clamped = BYTE_MAX;
        end
        else
        begin
            clamped = lerp_sum[7:0];
        end
    end

    assign fire = th_reg > (BYTE_MAX - density_reg[lane_reg]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_MX0;
                end
            end
            ST_MX0: state_next = ST_MX1;
            ST_MX1: state_next = ST_MY;
            ST_MY:  state_next = ST_TH;
            ST_TH:  state_next = (randomness_reg != 8'd0) ? ST_JMUL : ST_FIRE;
            ST_JMUL: state_next = ST_JADD;
            ST_JADD: state_next = ST_FIRE;
            ST_FIRE: state_next = (lane_reg == 2'(LANES - 1)) ? ST_DONE : ST_READ;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_x_reg      <= MAP_X_RESET;
            map_y_reg      <= MAP_Y_RESET;
            randomness_reg <= 8'd0;
            accent_reg     <= ACCENT_RESET;
            for (int i = 0; i < LANES; i++)
            begin
                density_reg[i] <= 8'd0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAP_X:      map_x_reg      <= cfg_data;
                CFG_MAP_Y:      map_y_reg      <= cfg_data;
                CFG_DENSITY0:   density_reg[0] <= cfg_data;
                CFG_DENSITY1:   density_reg[1] <= cfg_data;
                CFG_DENSITY2:   density_reg[2] <= cfg_data;
                CFG_RANDOMNESS: randomness_reg <= cfg_data;
                CFG_ACCENT:     accent_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            lcg_reg       <= LCG_SEED;
            lane_reg      <= 2'd0;
            cnt_reg       <= 2'd0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= mem_re;
            rd_idx_reg  <= cnt_reg;
            if (in_fire && (opcode_t'(opcode) == OP_RESTART))
            begin
                step_reg <= '0;
            end
            if (tick_fire)
            begin
                lane_reg <= 2'd0;
                cnt_reg  <= 2'd0;
            end
            if (state_reg == ST_READ)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (state_reg == ST_TH && randomness_reg != 8'd0)
            begin
                lcg_reg <= 32'(lcg_reg * LCG_MUL + LCG_INC);
            end
            if (state_reg == ST_FIRE && lane_reg != 2'(LANES - 1))
            begin
                lane_reg <= lane_reg + 2'd1;
            end
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= step_reg + STEP_W'(1);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            corner_reg[rd_idx_reg] <= mem_q_reg;
        end
        if (tick_fire)
        begin
            trig_reg <= 3'd0;
            acc_reg  <= 3'd0;
        end
        unique case (state_reg)
            ST_MX0, ST_MX1, ST_MY, ST_JMUL:
            begin
                prod_reg <= mul_res;
                if (state_reg == ST_MX1)
                begin
                    r0_reg <= lerp_sum[7:0];
                end
            end
            ST_TH:
            begin
                th_reg      <= lerp_sum[7:0];
                acc_hit_reg <= lerp_sum[7:0] >= accent_reg;
            end
            ST_JADD: th_reg <= clamped;
            ST_FIRE:
            begin
                trig_reg[lane_reg] <= fire;
                acc_reg[lane_reg]  <= fire && acc_hit_reg;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_trig_reg  <= trig_reg;
                    out_acc_reg   <= acc_reg;
                    eval_step_reg <= step_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accent_needs_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((accent_mask & ~trigger_mask) == 3'd0))
        else $error("accent without trigger");

    a_tick_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> (state_reg == ST_READ && cnt_reg == 2'd0 && lane_reg == 2'd0))
        else $error("tick did not start corner reads");

    a_last_corner_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MX0) |-> (rd_pend_reg && rd_idx_reg == 2'd3))
        else $error("corner read pipeline out of step");

    a_jitter_only_random: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_JMUL) |-> (randomness_reg != 8'd0 && $past(state_reg) == ST_TH))
        else $error("jitter path entered without randomness");

    a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && state_next == ST_IDLE)
        |=> (evaluated_step + 5'd1 == step_reg && out_valid))
        else $error("step counter out of step with result");
`endif

endmodule

`default_nettype wire

>>> sim/drum_pattern_map_generator_test.sv
// Self-checking testbench for drum_pattern_map_generator: directed and random tick, load and
// restart transactions under random stalls, checked against an in-bench pattern predictor.
// Depends on dpmg_pkg and the drum_pattern_map_generator RTL.
module drum_pattern_map_generator_test;
    import dpmg_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int PRESSURE_PHASE  = 5;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] lane;
        logic [4:0] node;
        logic [4:0] step;
        logic [7:0] value;
    } command_t;

    typedef struct packed {
        logic [2:0] trigger;
        logic [2:0] accent;
        logic [4:0] step;
    } hit_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [1:0] opcode     = OP_TICK;
    logic [1:0] load_lane  = '0;
    logic [4:0] load_node  = '0;
    logic [4:0] load_step  = '0;
    logic [7:0] load_value = '0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [2:0] trigger_mask;
    logic [2:0] accent_mask;
    logic [4:0] evaluated_step;
    logic       cfg_we     = 1'b0;
    logic [2:0] cfg_index  = '0;
    logic [7:0] cfg_data   = '0;

    // predictor state
    logic [7:0]  energy_table [MEM_DEPTH];
    logic [7:0]  model_map_x      = MAP_X_RESET;
    logic [7:0]  model_map_y      = MAP_Y_RESET;
    logic [7:0]  model_density [LANES] = '{default: 8'd0};
    logic [7:0]  model_randomness = 8'd0;
    logic [7:0]  model_accent     = ACCENT_RESET;
    logic [4:0]  model_step       = '0;
    logic [31:0] jitter_seed      = LCG_SEED;

    command_t command_queue [$];
    hit_t     expected_hits [$];
    int       queued_count    = 0;
    int       accepted_count  = 0;
    int       mismatch_count  = 0;
    int       cycle_count     = 0;
    logic     in_taken        = 1'b0;
    int       burst_left      = 0;
    int       gap_left        = 0;
    int       hold_left       = 0;
    int       holds_requested = 0;
    int       holds_served    = 0;
    int       pattern_left    = 0;
    int       stall_percent   = 0;

    drum_pattern_map_generator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .load_lane      (load_lane),
        .load_node      (load_node),
        .load_step      (load_step),
        .load_value     (load_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .trigger_mask   (trigger_mask),
        .accent_mask    (accent_mask),
        .evaluated_step (evaluated_step),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    // a + floor((b - a) * t / 256)
    function automatic int lerp_energy(int a, int b, int t);
        return (a + (((b - a) * t) >>> 8)) & 255;
    endfunction

    function automatic int node_energy(int lane, int nx, int ny, int s);
        return int'(energy_table[ADDR_W'((lane * NODE_COUNT + ny * MAP_NODES + nx) * STEPS
                                         + s)]);
    endfunction

    function automatic hit_t predict_tick();
        hit_t hit;
        int   s, xc, yc, xf, yf, r0, r1, th, jit;
        logic accent;
        s  = int'(model_step);
        xc = int'(model_map_x[7:6]);
        yc = int'(model_map_y[7:6]);
        xf = int'({model_map_x[5:0], 2'b00});
        yf = int'({model_map_y[5:0], 2'b00});
        hit = '0;
        hit.step = model_step;
        for (int lane = 0; lane < LANES; lane++) begin
            r0 = lerp_energy(node_energy(lane, xc, yc, s), node_energy(lane, xc + 1, yc, s), xf);
            r1 = lerp_energy(node_energy(lane, xc, yc + 1, s),
                             node_energy(lane, xc + 1, yc + 1, s), xf);
            th = lerp_energy(r0, r1, yf);
            accent = (th >= int'(model_accent));
            if (model_randomness != 8'd0) begin
                jitter_seed = jitter_seed * LCG_MUL + LCG_INC;
                jit = ((int'(jitter_seed[23:16]) - 128) * int'(model_randomness)) >>> 8;
                th = th + jit;
                if (th < 0)
                    th = 0;
                if (th > int'(BYTE_MAX))
                    th = int'(BYTE_MAX);
            end
            if (th > int'(BYTE_MAX) - int'(model_density[lane])) begin
                hit.trigger[lane] = 1'b1;
                hit.accent[lane]  = accent;
            end
        end
        model_step = model_step + 5'd1;
        return hit;
    endfunction

    function automatic void apply_command(command_t cmd);
        case (cmd.opcode)
            OP_LOAD:
                if (cmd.lane < LANES && cmd.node < NODE_COUNT)
                    energy_table[ADDR_W'((cmd.lane * NODE_COUNT + cmd.node) * STEPS
                                         + cmd.step)] = cmd.value;
            OP_RESTART:
                model_step = '0;
            OP_TICK:
                expected_hits.push_back(predict_tick());
            default: ;
        endcase
    endfunction

    function automatic void apply_setting(logic [2:0] idx, logic [7:0] value);
        case (idx)
            CFG_MAP_X:      model_map_x = value;
            CFG_MAP_Y:      model_map_y = value;
            CFG_DENSITY0:   model_density[0] = value;
            CFG_DENSITY1:   model_density[1] = value;
            CFG_DENSITY2:   model_density[2] = value;
            CFG_RANDOMNESS: model_randomness = value;
            CFG_ACCENT:     model_accent = value;
            default: ;
        endcase
    endfunction

    function automatic void push_command(logic [1:0] op, int lane, int node, int step, int value);
        command_t cmd;
        cmd.opcode = op;
        cmd.lane   = 2'(lane);
        cmd.node   = 5'(node);
        cmd.step   = 5'(step);
        cmd.value  = 8'(value);
        command_queue.push_back(cmd);
        queued_count++;
    endfunction

    function automatic command_t random_command();
        command_t cmd;
        int       pick;
        pick      = $urandom_range(0, 999);
        cmd.lane  = 2'($urandom_range(0, LANES - 1));
        cmd.node  = 5'($urandom_range(0, NODE_COUNT - 1));
        cmd.step  = 5'($urandom_range(0, STEPS - 1));
        cmd.value = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
            cmd.lane = 2'($urandom_range(0, 3));
            cmd.node = 5'($urandom_range(0, 31));
        end
        if (pick < 700)
            cmd.opcode = OP_TICK;
        else if (pick < 970)
            cmd.opcode = OP_LOAD;
        else if (pick < 985)
            cmd.opcode = OP_RESTART;
        else
            cmd.opcode = OP_UNUSED;
        return cmd;
    endfunction

    function automatic logic [7:0] phase_setting(int phase, int idx);
        if (phase == 0)
            return 8'd0;
        if (phase == 1)
            return BYTE_MAX;
        case (idx)
            CFG_MAP_X:
                return (phase == 2) ? BYTE_MAX : 8'($urandom_range(0, 255));
            CFG_MAP_Y:
                return (phase == 2) ? 8'd0 : 8'($urandom_range(0, 255));
            CFG_RANDOMNESS:
                return (phase == 2 || $urandom_range(0, 1) == 0) ? 8'd0
                                                                   : 8'($urandom_range(1, 255));
            CFG_ACCENT:
                return 8'($urandom_range(0, 255));
            default:
                case ($urandom_range(0, 5))
                    0:       return 8'd0;
                    1:       return BYTE_MAX;
                    default: return 8'($urandom_range(0, 255));
                endcase
        endcase
    endfunction

    task automatic write_setting(logic [2:0] idx, logic [7:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        apply_setting(idx, value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (accepted_count != queued_count || expected_hits.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // sender: bursts of transactions with random gaps
    always @(negedge clk) begin : driver_proc
        command_t cmd;
        if (rst_n && (!in_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (command_queue.size() > 0) begin
                cmd = command_queue.pop_front();
                {opcode, load_lane, load_node, load_step, load_value} <= cmd;
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern in segments, plus long hold-offs on request
    always @(negedge clk) begin : receiver_proc
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (holds_served != holds_requested) begin
                holds_served <= holds_served + 1;
                hold_left    <= HOLD_OFF_CYCLES;
                out_ready    <= 1'b0;
            end
            else begin
                if (pattern_left == 0) begin
                    pattern_left <= $urandom_range(4, 60);
                    case ($urandom_range(0, 3))
                        0:       stall_percent <= 0;
                        1:       stall_percent <= 25;
                        2:       stall_percent <= 50;
                        default: stall_percent <= 85;
                    endcase
                end
                else
                    pattern_left <= pattern_left - 1;
                out_ready <= ($urandom_range(0, 99) >= stall_percent);
            end
        end
    end

    always @(posedge clk) begin : monitor_proc
        command_t cmd;
        hit_t     got;
        hit_t     want;
        if (rst_n) begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                cmd = {opcode, load_lane, load_node, load_step, load_value};
                accepted_count++;
                apply_command(cmd);
            end
            if (out_valid && out_ready) begin
                got = {trigger_mask, accent_mask, evaluated_step};
                if (expected_hits.size() == 0) begin
                    $error("result transaction with no tick pending: trigger %0d accent %0d step %0d",
                           got.trigger, got.accent, got.step);
                    mismatch_count++;
                end
                else begin
                    want = expected_hits.pop_front();
                    if (got.trigger !== want.trigger) begin
                        $error("trigger_mask mismatch: expected %0d, actual %0d",
                               want.trigger, got.trigger);
                        mismatch_count++;
                    end
                    if (got.accent !== want.accent) begin
                        $error("accent_mask mismatch: expected %0d, actual %0d",
                               want.accent, got.accent);
                        mismatch_count++;
                    end
                    if (got.step !== want.step) begin
                        $error("evaluated_step mismatch: expected %0d, actual %0d",
                               want.step, got.step);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog_proc
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : sequence_proc
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill the whole pattern table so every tick reads written entries
        for (int lane = 0; lane < LANES; lane++)
            for (int node = 0; node < NODE_COUNT; node++)
                for (int s = 0; s < STEPS; s++)
                    push_command(OP_LOAD, lane, node, s, $urandom_range(0, 255));

        // reset config: centre node, zero density, so full energy passes the accent level but never fires
        push_command(OP_LOAD, 0, 2 * MAP_NODES + 2, 0, BYTE_MAX);
        push_command(OP_LOAD, LANES - 1, NODE_COUNT - 1, STEPS - 1, 0);
        push_command(OP_LOAD, 1, 0, 0, BYTE_MAX);
        push_command(OP_LOAD, LANES, 2 * MAP_NODES + 2, 0, 0);
        push_command(OP_LOAD, 0, NODE_COUNT, 0, 0);
        push_command(OP_LOAD, 3, 31, STEPS - 1, BYTE_MAX);
        push_command(OP_UNUSED, 3, 31, STEPS - 1, BYTE_MAX);
        push_command(OP_TICK, 0, 0, 0, 0);
        push_command(OP_TICK, 3, 31, 31, BYTE_MAX);
        push_command(OP_TICK, 0, 0, 0, 0);
        push_command(OP_RESTART, 0, 0, 0, 0);
        push_command(OP_TICK, 0, 0, 0, 0);
        push_command(OP_UNUSED, 0, 0, 0, 0);
        push_command(OP_TICK, 0, 0, 0, 0);
        wait_for_quiet();

        for (int phase = 0; phase < PHASES; phase++) begin
            for (int i = CFG_MAP_X; i <= CFG_ACCENT; i++)
                write_setting(3'(i), phase_setting(phase, i));
            if (phase == PHASES - 1)
                write_setting(CFG_UNUSED, 8'($urandom_range(0, 255)));
            if (phase == PRESSURE_PHASE) begin
                holds_requested++;
                repeat (40) push_command(OP_TICK, 0, 0, 0, 0);
            end
            repeat (ITEMS_PER_PHASE) begin
                command_queue.push_back(random_command());
                queued_count++;
            end
            wait_for_quiet();
        end

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
